@@ hdl/susb_pkg.sv @@
`default_nettype none

package susb_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 7;
  localparam int unsigned COUNT_W = 8;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_READ   = 1'b1
  } req_kind_t;

  typedef struct packed {
    req_kind_t                   req_type;
    logic signed [VALUE_W-1:0]   item_value;
    logic        [INDEX_W-1:0]   read_index;
    logic                        batch_last;
  } request_t;

  typedef struct packed {
    logic                        was_added;
    logic                        dropped_full;
    logic        [COUNT_W-1:0]   entry_count;
    logic signed [VALUE_W-1:0]   read_value;
    logic                        read_valid;
    logic                        batch_done;
  } result_t;

  typedef struct packed {
    logic                        cmp;
    logic                        shift;
    logic signed [VALUE_W-1:0]   value;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ hdl/susb_cell.sv @@
`default_nettype none

module susb_cell (
  input  wire                                       clk,
  input  wire                                       rst,
  input  wire  susb_pkg::cell_ctl_t                 ctl,
  input  wire                                       present,
  input  wire                                       rd_sel,
  input  wire                                       left_present,
  input  wire                                       left_gt,
  input  wire  logic signed [susb_pkg::VALUE_W-1:0] left_entry,
  output logic signed [susb_pkg::VALUE_W-1:0]       entry,
  output logic                                      gt,
  output logic                                      eq,
  output logic        [susb_pkg::VALUE_W-1:0]       rd_value
);

  logic place;

  assign place = !left_gt && left_present && (!present || gt);

  always_ff @(posedge clk) begin
    if (rst) begin
      gt <= 1'b0;
      eq <= 1'b0;
    end else if (ctl.cmp) begin
      gt <= present && (ctl.value < entry);
      eq <= present && (ctl.value == entry);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      rd_value <= (present && rd_sel) ? entry : '0;
    end
  end

  // advance the larger entries by one and drop the new value into its slot
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      if (left_gt) begin
        entry <= left_entry;
      end else if (place) begin
        entry <= ctl.value;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/sorted_unique_set_builder.sv @@
// Channel  | Ports                  | Transaction
// ---------+------------------------+--------------------------------------
// request  | start, busy, request   | taken when start is high, busy low
// result   | done, result           | one cycle, marked by done, no stall
//
// A request steps through capture, compare in every cell of the chain,
// then shift the chain (added inserts only) and register the result.
// busy stays high from capture until the result cycle; the next request
// may start in the cycle that done is high. Synchronous reset empties the
// set. The result cannot be held off; it is shown for exactly one cycle.

`default_nettype none

module sorted_unique_set_builder #(
  parameter int unsigned CAPACITY = 128
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  wire susb_pkg::request_t request,
  output logic                 done,
  output susb_pkg::result_t    result
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = CNT_W + susb_pkg::INDEX_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } state_t;

  state_t              state;
  susb_pkg::request_t  req;
  logic [CNT_W-1:0]    count;
  susb_pkg::cell_ctl_t ctl;

  logic signed [susb_pkg::VALUE_W-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]                 gt;
  logic [CAPACITY-1:0]                 eq;
  logic [CAPACITY-1:0]                 present;
  logic [susb_pkg::VALUE_W-1:0]        rd_value [CAPACITY];

  logic                         found;
  logic                         full;
  logic                         is_insert;
  logic                         do_insert;
  logic                         in_range;
  logic [susb_pkg::VALUE_W-1:0] rd_any;

  assign busy      = (state != ST_IDLE);
  assign is_insert = (req.req_type == susb_pkg::REQ_INSERT);
  assign found     = |eq;
  assign full      = (count == CNT_W'(CAPACITY));
  assign do_insert = (state == ST_APPLY) && is_insert && !found && !full;
  assign in_range  = CMP_W'(req.read_index) < CMP_W'(count);

  assign ctl.cmp   = (state == ST_CMP);
  assign ctl.shift = do_insert;
  assign ctl.value = req.item_value;

  always_comb begin
    rd_any = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_any = rd_any | rd_value[k];
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                                left_present;
    logic                                left_gt;
    logic signed [susb_pkg::VALUE_W-1:0] left_entry;
    logic                                rd_sel;

    assign present[i] = CNT_W'(i) < count;

    if (i == 0) begin : g_first
      assign left_present = 1'b1;
      assign left_gt      = 1'b0;
      assign left_entry   = '0;
    end else begin : g_rest
      assign left_present = present[i-1];
      assign left_gt      = gt[i-1];
      assign left_entry   = entry[i-1];
    end

    if (i < (1 << susb_pkg::INDEX_W)) begin : g_rd
      assign rd_sel = (req.read_index == susb_pkg::INDEX_W'(i));
    end else begin : g_no_rd
      assign rd_sel = 1'b0;
    end

    susb_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .present      (present[i]),
      .rd_sel       (rd_sel),
      .left_present (left_present),
      .left_gt      (left_gt),
      .left_entry   (left_entry),
      .entry        (entry[i]),
      .gt           (gt[i]),
      .eq           (eq[i]),
      .rd_value     (rd_value[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      done   <= 1'b0;
      result <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            req   <= request;
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          if (do_insert) begin
            count <= count + CNT_W'(1);
          end
          result.was_added    <= do_insert;
          result.dropped_full <= is_insert && !found && full;
          result.entry_count  <= susb_pkg::COUNT_W'(do_insert ? count + CNT_W'(1) : count);
          result.read_valid   <= !is_insert && in_range;
          result.read_value   <= (!is_insert && in_range) ? rd_any : '0;
          result.batch_done   <= req.batch_last;
          done                <= 1'b1;
          state               <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import susb_pkg::*;

  localparam int SET_CAP      = 128;
  localparam int RANDOM_ITEMS = 1725;
  localparam int DIR_ROWS     = 25;

  localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] V_NEG = 32'shffff_ffff;

  typedef struct packed {
    request_t req;
    logic     typed;
    result_t  res;
  } dir_row_t;

  // result fields: was_added, dropped_full, entry_count, read_value, read_valid, batch_done
  localparam dir_row_t DIRECTED_TAB [DIR_ROWS] = '{
    '{'{REQ_READ,   32'sh0,         7'd0,   1'b1}, 1'b1, '{1'b0, 1'b0, 8'd0, 32'sh0, 1'b0, 1'b1}},
    '{'{REQ_INSERT, 32'sh0,         7'h7f,  1'b0}, 1'b1, '{1'b1, 1'b0, 8'd1, 32'sh0, 1'b0, 1'b0}},
    '{'{REQ_INSERT, V_MIN,          7'd0,   1'b0}, 1'b1, '{1'b1, 1'b0, 8'd2, 32'sh0, 1'b0, 1'b0}},
    '{'{REQ_INSERT, V_MAX,          7'h55,  1'b1}, 1'b1, '{1'b1, 1'b0, 8'd3, 32'sh0, 1'b0, 1'b1}},
    '{'{REQ_INSERT, 32'sh0,         7'h2a,  1'b0}, 1'b1, '{1'b0, 1'b0, 8'd3, 32'sh0, 1'b0, 1'b0}},
    '{'{REQ_READ,   V_MAX,          7'd0,   1'b0}, 1'b1, '{1'b0, 1'b0, 8'd3, V_MIN,  1'b1, 1'b0}},
    '{'{REQ_READ,   V_MIN,          7'd1,   1'b0}, 1'b1, '{1'b0, 1'b0, 8'd3, 32'sh0, 1'b1, 1'b0}},
    '{'{REQ_READ,   32'sh0,         7'd2,   1'b0}, 1'b1, '{1'b0, 1'b0, 8'd3, V_MAX,  1'b1, 1'b0}},
    '{'{REQ_READ,   32'sh0,         7'd3,   1'b0}, 1'b1, '{1'b0, 1'b0, 8'd3, 32'sh0, 1'b0, 1'b0}},
    '{'{REQ_READ,   V_NEG,          7'd127, 1'b1}, 1'b1, '{1'b0, 1'b0, 8'd3, 32'sh0, 1'b0, 1'b1}},
    '{'{REQ_INSERT, V_NEG,          7'd0,   1'b0}, 1'b1, '{1'b1, 1'b0, 8'd4, 32'sh0, 1'b0, 1'b0}},
    '{'{REQ_INSERT, 32'sh1,         7'd0,   1'b0}, 1'b1, '{1'b1, 1'b0, 8'd5, 32'sh0, 1'b0, 1'b0}},
    '{'{REQ_INSERT, V_MAX,          7'd0,   1'b1}, 1'b1, '{1'b0, 1'b0, 8'd5, 32'sh0, 1'b0, 1'b1}},
    '{'{REQ_INSERT, V_MIN,          7'd0,   1'b0}, 1'b1, '{1'b0, 1'b0, 8'd5, 32'sh0, 1'b0, 1'b0}},
    '{'{REQ_INSERT, 32'sh8000_0001, 7'd0,   1'b0}, 1'b1, '{1'b1, 1'b0, 8'd6, 32'sh0, 1'b0, 1'b0}},
    '{'{REQ_INSERT, 32'sh7fff_fffe, 7'd0,   1'b0}, 1'b1, '{1'b1, 1'b0, 8'd7, 32'sh0, 1'b0, 1'b0}},
    '{'{REQ_READ,   32'sh0,         7'd1,   1'b0}, 1'b1,
      '{1'b0, 1'b0, 8'd7, 32'sh8000_0001, 1'b1, 1'b0}},
    '{'{REQ_READ,   32'sh0,         7'd2,   1'b0}, 1'b1, '{1'b0, 1'b0, 8'd7, V_NEG,  1'b1, 1'b0}},
    '{'{REQ_READ,   32'sh0,         7'd5,   1'b0}, 1'b1,
      '{1'b0, 1'b0, 8'd7, 32'sh7fff_fffe, 1'b1, 1'b0}},
    '{'{REQ_READ,   32'sh0,         7'd6,   1'b1}, 1'b1, '{1'b0, 1'b0, 8'd7, V_MAX,  1'b1, 1'b1}},
    '{'{REQ_INSERT, 32'sh1234_5678, 7'd0,   1'b0}, 1'b0, '0},
    '{'{REQ_INSERT, 32'shedcb_a988, 7'd0,   1'b0}, 1'b0, '0},
    '{'{REQ_READ,   32'sh0,         7'd7,   1'b0}, 1'b0, '0},
    '{'{REQ_READ,   32'sh0,         7'd8,   1'b1}, 1'b0, '0},
    '{'{REQ_READ,   32'sh0,         7'd9,   1'b0}, 1'b0, '0}
  };

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     done;
  result_t  result;

  logic signed [VALUE_W-1:0] set_mem [SET_CAP];
  int                        set_count = 0;
  result_t                   pending_results [$];
  int                        mismatch_count = 0;
  int                        batch_left = 1;
  int                        steady_left = 0;
  result_t                   want_res;

  sorted_unique_set_builder #(.CAPACITY(SET_CAP)) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always #5 clk = ~clk;

  function automatic result_t update_set(request_t rq);
    result_t rs;
    int      pos;
    bit      found;
    rs = '0;
    rs.batch_done = rq.batch_last;
    if (rq.req_type == REQ_INSERT) begin
      pos = set_count;
      found = 1'b0;
      for (int i = 0; i < set_count; i++) begin
        if (set_mem[i] == rq.item_value) begin
          found = 1'b1;
          break;
        end
        if (rq.item_value < set_mem[i]) begin
          pos = i;
          break;
        end
      end
      if (!found) begin
        if (set_count >= SET_CAP) begin
          rs.dropped_full = 1'b1;
        end else begin
          for (int j = set_count; j > pos; j--) set_mem[j] = set_mem[j-1];
          set_mem[pos] = rq.item_value;
          set_count++;
          rs.was_added = 1'b1;
        end
      end
    end else if (int'(rq.read_index) < set_count) begin
      rs.read_value = set_mem[rq.read_index];
      rs.read_valid = 1'b1;
    end
    rs.entry_count = COUNT_W'(set_count);
    return rs;
  endfunction

  function automatic request_t random_request();
    request_t rq;
    int       near;
    rq.read_index = INDEX_W'($urandom_range(0, 127));
    rq.item_value = $urandom;
    rq.batch_last = (batch_left <= 1);
    if (batch_left <= 1) batch_left = $urandom_range(1, 16);
    else batch_left--;
    if ($urandom_range(0, 99) < 40) begin
      rq.req_type = REQ_READ;
      if ($urandom_range(0, 9) < 4) begin
        near = set_count + int'($urandom_range(0, 2)) - 1;
        if (near < 0) near = 0;
        if (near > 127) near = 127;
        rq.read_index = INDEX_W'(near);
      end
    end else begin
      rq.req_type = REQ_INSERT;
      if (set_count > 0 && $urandom_range(0, 99) < 75) begin
        rq.item_value = set_mem[$urandom_range(0, set_count - 1)];
      end else begin
        case ($urandom_range(0, 3))
          1: rq.item_value = $urandom_range(0, 1) ? V_MAX - $urandom_range(0, 3)
                                                  : V_MIN + $urandom_range(0, 3);
          2: rq.item_value = $signed($urandom_range(0, 16)) - 8;
          3: if (set_count > 0) begin
            rq.item_value = set_mem[$urandom_range(0, set_count - 1)]
                            + ($urandom_range(0, 1) ? 1 : -1);
          end
          default: ;
        endcase
      end
    end
    return rq;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send(request_t rq, logic typed, result_t typed_res);
    int      gap;
    result_t pred;
    gap = 0;
    if (steady_left > 0) steady_left--;
    else if ($urandom_range(0, 49) == 0) steady_left = $urandom_range(20, 80);
    else gap = idle_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request <= rq;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    pred = update_set(rq);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result transaction: %p", result);
      end else begin
        want_res = pending_results.pop_front();
        if (result.was_added    !== want_res.was_added    ||
            result.dropped_full !== want_res.dropped_full ||
            result.entry_count  !== want_res.entry_count  ||
            result.read_value   !== want_res.read_value   ||
            result.read_valid   !== want_res.read_valid   ||
            result.batch_done   !== want_res.batch_done) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected %p, got %p", want_res, result);
        end
      end
    end
  end

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int k = 0; k < DIR_ROWS; k++)
      send(DIRECTED_TAB[k].req, DIRECTED_TAB[k].typed, DIRECTED_TAB[k].res);
    for (int k = 0; k < RANDOM_ITEMS; k++) send(random_request(), 1'b0, '0);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("sorted_unique_set_builder verification clean");
    else $display("sorted_unique_set_builder verification failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("sorted_unique_set_builder verification failed");
    $finish;
  end

endmodule
